// ===== rtl/core/bb3_pkg.sv =====
// bb3_pkg: shared types, widths and constants of the 3x3 box blur unit
// no dependencies; used by every module in rtl/core
`timescale 1ns / 1ps

package bb3_pkg;

  // frame limits and field widths
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MinDim     = 2;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;

  // stream word widths
  localparam int unsigned InTdataW   = 24;
  localparam int unsigned OutTdataW  = 48;
  localparam int unsigned OutPadW    = OutTdataW - NumChan * ChanW - RowW - ColW;

  // column sum of up to three pixels, window sum of up to nine plus bias
  localparam int unsigned ColSumW    = 10;
  localparam int unsigned SumW       = 12;

  // reciprocals scaled by 2^RecipShift, exact for the biased sums that occur
  localparam int unsigned RecipW     = 15;
  localparam int unsigned RecipShift = 16;
  localparam logic [RecipW-1:0] RecipFour = 15'd16384;
  localparam logic [RecipW-1:0] RecipSix  = 15'd10923;
  localparam logic [RecipW-1:0] RecipNine = 15'd7282;

  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

  typedef enum logic {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  // number of pixels averaged
  typedef enum logic [1:0] {
    DivFour = 2'd0,
    DivSix  = 2'd1,
    DivNine = 2'd2
  } div_e;

  // index 0 red, 1 green, 2 blue
  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  // one line store entry: the row two above and the row one above
  typedef struct packed {
    pixel_t older;
    pixel_t prev;
  } line_t;

  // one averaging job handed to the divide stage
  typedef struct packed {
    logic [NumChan-1:0][SumW-1:0] sum;
    div_e                         div;
    logic [RowW-1:0]              row;
    logic [ColW-1:0]              col;
    logic                         last;
  } mean_req_t;

endpackage

// ===== rtl/core/box_blur_3x3_rgb_unit.sv =====
// box_blur_3x3_rgb_unit: streaming 3x3 box blur over raster-order rgb frames
// depends on bb3_pkg, bb3_line_store and bb3_mean_unit
`timescale 1ns / 1ps

//  channel   dir  handshake                  word
//  cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i (width or height)
//  s_axis    in   s_axis_tvalid / tready     one rgb pixel, raster order
//  m_axis    out  m_axis_tvalid / tready     blurred pixel, row, column, tlast
//
//  one pixel per cycle while each pixel yields at most one result; a pixel on the last
//  column or last row, outside row 0 and column 0, yields two words, the final pixel of
//  a frame four, and the single result port holds the input while sending each extra word
//  stages from pixel accept to first result word: line store read, window/column sums,
//  result sequencer, divide + output register
//  reset clears position, window and pipeline valids; line store needs no clearing
//  a stall on m_axis backs up through the pipeline registers to s_axis_tready

module box_blur_3x3_rgb_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bb3_pkg::InTdataW-1:0]     s_axis_tdata,  // red_in, green_in, blue_in
  // blurred output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bb3_pkg::OutTdataW-1:0]    m_axis_tdata,  // red_out, green_out, blue_out,
                                                          // out_row, out_column, zero pad
  output logic                             m_axis_tlast   // run_last
);

  localparam int unsigned NumEmit = 4;
  // result slots per pixel, in emit order
  localparam int unsigned EmitCentre = 0;  // (r-1, c-1)
  localparam int unsigned EmitRight  = 1;  // (r-1, c) on the last column
  localparam int unsigned EmitBelow  = 2;  // (r, c-1) on the last row
  localparam int unsigned EmitCorner = 3;  // (r, c) on the last row and column

  localparam int unsigned NumRows = 3;
  localparam int unsigned NumCols = 3;

  typedef logic [NumCols-1:0][bb3_pkg::NumChan-1:0][bb3_pkg::ColSumW-1:0] col_sums_t;

  // ---------------------------------------------------------------------------
  // configuration, saturated on write
  // ---------------------------------------------------------------------------
  logic [bb3_pkg::WidthRegW-1:0]  width_q;
  logic [bb3_pkg::HeightRegW-1:0] height_q;
  logic [bb3_pkg::WidthRegW-1:0]  cfg_width;
  logic [bb3_pkg::HeightRegW-1:0] cfg_height;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_width  = cfg_data_i[bb3_pkg::WidthRegW-1:0];
    cfg_height = cfg_data_i[bb3_pkg::HeightRegW-1:0];
    if (cfg_width < bb3_pkg::WidthRegW'(bb3_pkg::MinDim)) begin
      cfg_width = bb3_pkg::WidthRegW'(bb3_pkg::MinDim);
    end else if (cfg_width > bb3_pkg::WidthRegW'(bb3_pkg::MaxWidth)) begin
      cfg_width = bb3_pkg::WidthRegW'(bb3_pkg::MaxWidth);
    end
    if (cfg_height < bb3_pkg::HeightRegW'(bb3_pkg::MinDim)) begin
      cfg_height = bb3_pkg::HeightRegW'(bb3_pkg::MinDim);
    end else if (cfg_height > bb3_pkg::HeightRegW'(bb3_pkg::MaxHeight)) begin
      cfg_height = bb3_pkg::HeightRegW'(bb3_pkg::MaxHeight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::WidthReset;
      height_q <= bb3_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (bb3_pkg::cfg_reg_e'(cfg_index_i))
        bb3_pkg::RegImageWidth:  width_q  <= cfg_width;
        bb3_pkg::RegImageHeight: height_q <= cfg_height;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: raster position, line store read
  // ---------------------------------------------------------------------------
  logic                           in_fire;
  logic [bb3_pkg::ColW-1:0]       col_q, col_d, cur_col;
  logic [bb3_pkg::RowW-1:0]       row_q, row_d, cur_row;
  logic                           col_over;
  logic [bb3_pkg::HeightRegW-1:0] row_pre;
  logic                           last_col, last_row;
  logic [NumEmit-1:0]             emit;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // a frame shrunk mid-frame may leave the position outside it
    col_over = bb3_pkg::WidthRegW'(col_q) >= width_q;
    cur_col  = col_over ? '0 : col_q;
    row_pre  = col_over ? bb3_pkg::HeightRegW'(row_q) + bb3_pkg::HeightRegW'(1)
                        : bb3_pkg::HeightRegW'(row_q);
    cur_row  = (row_pre >= height_q) ? '0 : row_pre[bb3_pkg::RowW-1:0];

    last_col = bb3_pkg::WidthRegW'(cur_col) == width_q - bb3_pkg::WidthRegW'(1);
    last_row = bb3_pkg::HeightRegW'(cur_row) == height_q - bb3_pkg::HeightRegW'(1);

    col_d = last_col ? '0 : cur_col + bb3_pkg::ColW'(1);
    row_d = last_col ? (last_row ? '0 : cur_row + bb3_pkg::RowW'(1)) : cur_row;

    emit[EmitCentre] = (|cur_row) && (|cur_col);
    emit[EmitRight]  = (|cur_row) && last_col;
    emit[EmitBelow]  = last_row && (|cur_col);
    emit[EmitCorner] = last_row && last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: window assembly, column sums, line store write-back
  // ---------------------------------------------------------------------------
  logic                     s1_valid_q;
  bb3_pkg::pixel_t          s1_pix_q;
  logic [bb3_pkg::RowW-1:0] s1_row_q;
  logic [bb3_pkg::ColW-1:0] s1_col_q;
  logic [NumEmit-1:0]       s1_emit_q;
  logic                     s1_row_ge2_q, s1_col_ge2_q;
  logic                     s1_adv;
  bb3_pkg::line_t           line_rd, line_wr;

  // window columns c-1 and c-2, entry k is frame row r-2+k
  bb3_pkg::pixel_t [NumRows-1:0] wcol_q, wold_q;
  bb3_pkg::pixel_t [NumRows-1:0] new_col;
  bb3_pkg::pixel_t [NumCols-1:0][NumRows-1:0] win;
  col_sums_t sum_a, sum_b;

  bb3_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (cur_col),
    .rd_data_o (line_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (line_wr)
  );

  // consecutive pixels always hit different entries (width is at least two),
  // so the write of one pixel lands before any later read of that entry
  assign line_wr.older = line_rd.prev;
  assign line_wr.prev  = s1_pix_q;

  always_comb begin
    new_col[0] = line_rd.older;
    new_col[1] = line_rd.prev;
    new_col[2] = s1_pix_q;
    win[0]     = wold_q;
    win[1]     = wcol_q;
    win[2]     = new_col;
    // sum_b: rows r-1 and r; sum_a adds row r-2 when it lies inside the frame
    for (int x = 0; x < NumCols; x++) begin
      for (int ch = 0; ch < bb3_pkg::NumChan; ch++) begin
        sum_b[x][ch] = bb3_pkg::ColSumW'(win[x][1][ch]) + bb3_pkg::ColSumW'(win[x][2][ch]);
        sum_a[x][ch] = sum_b[x][ch]
                     + (s1_row_ge2_q ? bb3_pkg::ColSumW'(win[x][0][ch]) : '0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: result sequencer; while the mean unit is ready, one averaging job per cycle
  // ---------------------------------------------------------------------------
  logic                     s2_valid_q;
  logic [NumEmit-1:0]       s2_pend_q;
  col_sums_t                s2_sum_a_q, s2_sum_b_q;
  logic [bb3_pkg::RowW-1:0] s2_row_q;
  logic [bb3_pkg::ColW-1:0] s2_col_q;
  logic                     s2_row_ge2_q, s2_col_ge2_q;
  logic [1:0]               pick;
  logic [NumEmit-1:0]       pend_next;
  logic                     below, right, use_left, three_rows;
  logic [bb3_pkg::SumW-1:0] bias;
  col_sums_t                sel;
  bb3_pkg::mean_req_t       req;
  logic                     req_ready, req_fire, s2_free, s1_has;

  always_comb begin
    if (s2_pend_q[EmitCentre]) begin
      pick = 2'(EmitCentre);
    end else if (s2_pend_q[EmitRight]) begin
      pick = 2'(EmitRight);
    end else if (s2_pend_q[EmitBelow]) begin
      pick = 2'(EmitBelow);
    end else begin
      pick = 2'(EmitCorner);
    end
    pend_next       = s2_pend_q;
    pend_next[pick] = 1'b0;

    // results below sit on the current row, results right on the current column
    below      = pick[1];
    right      = pick[0];
    use_left   = !right && s2_col_ge2_q;
    three_rows = !below && s2_row_ge2_q;
    sel        = below ? s2_sum_b_q : s2_sum_a_q;

    if (three_rows && use_left) begin
      req.div = bb3_pkg::DivNine;
    end else if (three_rows || use_left) begin
      req.div = bb3_pkg::DivSix;
    end else begin
      req.div = bb3_pkg::DivFour;
    end
    // half the count, floored: 2, 3 or 4
    bias = bb3_pkg::SumW'(2) + bb3_pkg::SumW'(three_rows) + bb3_pkg::SumW'(use_left);

    for (int ch = 0; ch < bb3_pkg::NumChan; ch++) begin
      req.sum[ch] = (use_left ? bb3_pkg::SumW'(sel[0][ch]) : '0)
                  + bb3_pkg::SumW'(sel[1][ch]) + bb3_pkg::SumW'(sel[2][ch]) + bias;
    end
    req.row  = below ? s2_row_q : s2_row_q - bb3_pkg::RowW'(1);
    req.col  = right ? s2_col_q : s2_col_q - bb3_pkg::ColW'(1);
    req.last = ~|pend_next;
  end

  assign req_fire      = s2_valid_q && req_ready;
  assign s2_free       = !s2_valid_q || (req_fire && req.last);
  assign s1_has        = |s1_emit_q;
  assign s1_adv        = s1_valid_q && (!s1_has || s2_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  // control state and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_pend_q  <= '0;
      wcol_q     <= '0;
      wold_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        wold_q <= wcol_q;
        wcol_q <= new_col;
      end
      if (s1_adv && s1_has) begin
        s2_valid_q <= 1'b1;
        s2_pend_q  <= s1_emit_q;
      end else if (req_fire) begin
        s2_pend_q <= pend_next;
        if (req.last) begin
          s2_valid_q <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q     <= s_axis_tdata;
      s1_row_q     <= cur_row;
      s1_col_q     <= cur_col;
      s1_emit_q    <= emit;
      s1_row_ge2_q <= |cur_row[bb3_pkg::RowW-1:1];
      s1_col_ge2_q <= |cur_col[bb3_pkg::ColW-1:1];
    end
    if (s1_adv && s1_has) begin
      s2_sum_a_q   <= sum_a;
      s2_sum_b_q   <= sum_b;
      s2_row_q     <= s1_row_q;
      s2_col_q     <= s1_col_q;
      s2_row_ge2_q <= s1_row_ge2_q;
      s2_col_ge2_q <= s1_col_ge2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3/4: divide and output register
  // ---------------------------------------------------------------------------
  bb3_pkg::pixel_t          out_pix;
  logic [bb3_pkg::RowW-1:0] out_row;
  logic [bb3_pkg::ColW-1:0] out_col;

  bb3_mean_unit u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s2_valid_q),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{bb3_pkg::OutPadW{1'b0}}, out_col, out_row, out_pix};

endmodule

// ===== rtl/core/bb3_line_store.sv =====
// bb3_line_store: simple dual-port line memory holding the two rows above
// depends on bb3_pkg; one write and one registered read per cycle
`timescale 1ns / 1ps

module bb3_line_store (
  input  logic                    clk_i,
  input  logic                    rd_en_i,
  input  logic [bb3_pkg::ColW-1:0] rd_addr_i,
  output bb3_pkg::line_t          rd_data_o,
  input  logic                    wr_en_i,
  input  logic [bb3_pkg::ColW-1:0] wr_addr_i,
  input  bb3_pkg::line_t          wr_data_i
);

  bb3_pkg::line_t mem_q [bb3_pkg::MaxWidth];
  bb3_pkg::line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/bb3_mean_unit.sv =====
// bb3_mean_unit: divides biased window sums by 4, 6 or 9 via reciprocals
// depends on bb3_pkg; two registered stages, the second is the output word
`timescale 1ns / 1ps

module bb3_mean_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  bb3_pkg::mean_req_t       req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bb3_pkg::pixel_t          out_pix_o,
  output logic [bb3_pkg::RowW-1:0] out_row_o,
  output logic [bb3_pkg::ColW-1:0] out_col_o,
  output logic                     out_last_o
);

  localparam int unsigned ProdW = bb3_pkg::SumW + bb3_pkg::RecipW;

  logic                                       a_valid_q;
  bb3_pkg::mean_req_t                         a_q;
  logic                                       o_valid_q;
  bb3_pkg::pixel_t                            o_pix_q;
  logic [bb3_pkg::RowW-1:0]                   o_row_q;
  logic [bb3_pkg::ColW-1:0]                   o_col_q;
  logic                                       o_last_q;
  logic                                       a_adv;
  logic [bb3_pkg::RecipW-1:0]                 recip;
  logic [bb3_pkg::NumChan-1:0][ProdW-1:0]     prod;
  bb3_pkg::pixel_t                            quot;

  assign a_adv       = a_valid_q && (!o_valid_q || out_ready_i);
  assign req_ready_o = !a_valid_q || a_adv;

  always_comb begin
    unique case (a_q.div)
      bb3_pkg::DivFour: recip = bb3_pkg::RecipFour;
      bb3_pkg::DivSix:  recip = bb3_pkg::RecipSix;
      bb3_pkg::DivNine: recip = bb3_pkg::RecipNine;
      default:          recip = bb3_pkg::RecipFour;
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < bb3_pkg::NumChan; ch++) begin
      prod[ch] = ProdW'(a_q.sum[ch]) * ProdW'(recip);
      quot[ch] = prod[ch][bb3_pkg::RecipShift +: bb3_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        a_valid_q <= req_valid_i;
      end
      if (a_adv) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      a_q <= req_i;
    end
    if (a_adv) begin
      o_pix_q  <= quot;
      o_row_q  <= a_q.row;
      o_col_q  <= a_q.col;
      o_last_q <= a_q.last;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pix_o   = o_pix_q;
  assign out_row_o   = o_row_q;
  assign out_col_o   = o_col_q;
  assign out_last_o  = o_last_q;

endmodule

// ===== tb/tb_box_blur_3x3_rgb_unit.sv =====
// tb_box_blur_3x3_rgb_unit: self-checking bench for the streaming 3x3 rgb box blur
// streams whole and part frames in, predicts every blurred word and checks m_axis against it
// depends on bb3_pkg and box_blur_3x3_rgb_unit
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_unit;
  import bb3_pkg::*;

  localparam int unsigned TimeoutCycles = 600_000;
  // the last pixel of a frame adds three more words
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainCycles   = 4000;
  localparam int unsigned PixW          = NumChan * ChanW;

  // pixel as kept by the predictor: {red, green, blue}
  typedef logic [PixW-1:0] rgb_t;

  // one blurred word as it leaves m_axis
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
  } blur_word_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i   = RegImageWidth;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // red_in, green_in, blue_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // red_out, green_out, blue_out,
                                             // out_row, out_column, zero pad
  logic                 m_axis_tlast;        // run_last

  // blur predictor state: two line stores, the two columns left of the
  // current one (entries 0..2 rows r-2..r at c-1, entries 3..5 at c-2)
  rgb_t                  older_line  [MaxWidth];
  rgb_t                  prev_line   [MaxWidth];
  rgb_t                  window_cols [6];
  int unsigned           col_pos        = 0;
  int unsigned           row_pos        = 0;
  logic [WidthRegW-1:0]  width_setting  = WidthReset;
  logic [HeightRegW-1:0] height_setting = HeightReset;

  // blurred words owed by the block, oldest first
  blur_word_t pending_blur [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned pixels_sent    = 0;
  int unsigned words_checked  = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycle_count    = 0;

  box_blur_3x3_rgb_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // blur predictor
  // ---------------------------------------------------------------------------

  // register value as the block uses it: clamped to [2, hi]
  function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
    if (value < MinDim) return MinDim;
    if (value > hi) return hi;
    return value;
  endfunction

  // rounded mean of the in-frame neighbours of window position (wy, wx);
  // window row k is frame row r-2+k, window column k is frame column c-2+k
  function automatic blur_word_t mean_at(input logic [2:0][2:0][PixW-1:0] win,
                                         input int r, input int c, input int w, input int h,
                                         input int wy, input int wx, input logic last);
    int unsigned s_red, s_green, s_blue, n;
    int          y, x;
    blur_word_t  res;
    s_red   = 0;
    s_green = 0;
    s_blue  = 0;
    n       = 0;
    for (y = wy - 1; y <= wy + 1; y++) begin
      for (x = wx - 1; x <= wx + 1; x++) begin
        if (y >= 0 && y <= 2 && x >= 0 && x <= 2 &&
            r - 2 + y >= 0 && r - 2 + y < h && c - 2 + x >= 0 && c - 2 + x < w) begin
          s_red   += win[y][x][2*ChanW +: ChanW];
          s_green += win[y][x][ChanW +: ChanW];
          s_blue  += win[y][x][0 +: ChanW];
          n++;
        end
      end
    end
    // half up: floor((2*sum + n) / (2*n))
    res.red   = (n == 0) ? '0 : ChanW'((2 * s_red + n) / (2 * n));
    res.green = (n == 0) ? '0 : ChanW'((2 * s_green + n) / (2 * n));
    res.blue  = (n == 0) ? '0 : ChanW'((2 * s_blue + n) / (2 * n));
    res.row   = RowW'(r - 2 + wy);
    res.col   = ColW'(c - 2 + wx);
    res.last  = last;
    return res;
  endfunction

  // advance the predictor by one accepted pixel and queue the words it owes
  task automatic predict_blur(input rgb_t px);
    logic [2:0][2:0][PixW-1:0] win;
    int unsigned               w, h, idx, k;
    int                        r, c;
    logic                      last_col, last_row, e0, e1, e2, e3;
    w = clamp_dim(width_setting, MaxWidth);
    h = clamp_dim(height_setting, MaxHeight);
    // a frame shrunk under the current position wraps lazily here
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r   = row_pos;
    c   = col_pos;
    idx = col_pos % MaxWidth;
    for (k = 0; k < 3; k++) begin
      win[k][0] = window_cols[3 + k];
      win[k][1] = window_cols[k];
    end
    win[0][2] = older_line[idx];
    win[1][2] = prev_line[idx];
    win[2][2] = px;

    last_col = (col_pos == w - 1);
    last_row = (row_pos == h - 1);
    e0 = r >= 1 && c >= 1;
    e1 = r >= 1 && last_col;
    e2 = last_row && c >= 1;
    e3 = last_row && last_col;
    // centre one up-left, then right column, then bottom row, then bottom-right
    if (e0) pending_blur.push_back(mean_at(win, r, c, w, h, 1, 1, !(e1 || e2 || e3)));
    if (e1) pending_blur.push_back(mean_at(win, r, c, w, h, 1, 2, !(e2 || e3)));
    if (e2) pending_blur.push_back(mean_at(win, r, c, w, h, 2, 1, !e3));
    if (e3) pending_blur.push_back(mean_at(win, r, c, w, h, 2, 2, 1'b1));

    for (k = 0; k < 3; k++) begin
      window_cols[3 + k] = win[k][1];
      window_cols[k]     = win[k][2];
    end
    older_line[idx] = win[1][2];
    prev_line[idx]  = px;

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [RowW-1:0] got,
                             input logic [RowW-1:0] want, input blur_word_t at_word);
    if (got !== want)
      report_mismatch($sformatf("%s of pixel (%0d,%0d): got %0d, want %0d",
                                name, at_word.row, at_word.col, got, want));
  endtask

  task automatic check_word();
    blur_word_t got, want;
    got.red   = m_axis_tdata[0 +: ChanW];
    got.green = m_axis_tdata[ChanW +: ChanW];
    got.blue  = m_axis_tdata[2*ChanW +: ChanW];
    got.row   = m_axis_tdata[3*ChanW +: RowW];
    got.col   = m_axis_tdata[3*ChanW + RowW +: ColW];
    got.last  = m_axis_tlast;
    if (pending_blur.size() == 0) begin
      report_mismatch($sformatf("word for pixel (%0d,%0d) with none owed", got.row, got.col));
    end else begin
      want = pending_blur.pop_front();
      check_field("red", RowW'(got.red), RowW'(want.red), want);
      check_field("green", RowW'(got.green), RowW'(want.green), want);
      check_field("blue", RowW'(got.blue), RowW'(want.blue), want);
      check_field("row", got.row, want.row, want);
      check_field("column", RowW'(got.col), RowW'(want.col), want);
      check_field("tlast", RowW'(got.last), RowW'(want.last), want);
      words_checked++;
    end
  endtask

  // sample at the edge, then pick the receiver's readiness for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_blur.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one pixel through s_axis; tvalid stays high afterwards for back-to-back words
  task automatic send_pixel(input rgb_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px[0 +: ChanW], px[ChanW +: ChanW], px[2*ChanW +: ChanW]};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_blur(px);
    pixels_sent++;
  endtask

  // random pixel, with all-zero and all-one channels now and then
  function automatic rgb_t rand_rgb();
    rgb_t px;
    px = rgb_t'($urandom);
    case ($urandom_range(9))
      0: px[2*ChanW +: ChanW] = '1;
      1: px[ChanW +: ChanW]   = '0;
      2: px[0 +: ChanW]       = '1;
      3: px                   = '0;
      default: ;
    endcase
    return px;
  endfunction

  // random pixels; at index pause_at the stream holds until nothing is owed
  task automatic send_random_pixels(input int unsigned count, input int unsigned pause_at);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_blur.size() != 0);
      end
      send_pixel(rand_rgb());
    end
  endtask

  // wait until every owed word is out and the pipeline has gone quiet
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_blur.size() != 0 && waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_blur.size() != 0) begin
      report_mismatch($sformatf("%0d owed words never came, first for pixel (%0d,%0d)",
                                pending_blur.size(), pending_blur[0].row, pending_blur[0].col));
      pending_blur.delete();
    end
  endtask

  // cfg_valid_i is left high so that a second write can follow directly
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegImageWidth) width_setting = value[WidthRegW-1:0];
    else height_setting = value[HeightRegW-1:0];
    reg_writes++;
  endtask

  // frame size change, only once the block is idle
  task automatic set_frame(input logic [CfgDataW-1:0] width_data,
                           input logic [CfgDataW-1:0] height_data);
    drain_results();
    write_reg(RegImageWidth, width_data);
    write_reg(RegImageHeight, height_data);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned frame_pixels();
    return clamp_dim(width_setting, MaxWidth) * clamp_dim(height_setting, MaxHeight);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size 640 x 480: the head of the first row, then 8 x 4 carries on in the
  // same frame into the second row, which is then shrunk under the position so
  // both column and row wrap on the next pixel
  task automatic test_reset_size_and_shrink();
    send_random_pixels(5, 5);
    set_frame(8, 4);
    send_random_pixels(8, 8);
    // width data has bit 11 set beyond the register: 3 wide, 2 high
    set_frame(13'h0803, 2);
    send_random_pixels(6, 6);
  endtask

  // hand-picked pixels: corner, edge and interior means, rounding at the half
  task automatic test_directed_pixels();
    set_frame(3, 3);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h55AA01);
    send_pixel(24'hAA5580);
    send_pixel(24'h0180FE);
    send_pixel(24'h7FFE55);
    send_pixel(24'h8001AA);
    send_pixel(24'hFE7F7F);
    send_pixel(24'h00FF00);
    // sizes below the minimum clamp to 2 x 2; mean 0.5 rounds up
    set_frame(1, 0);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h020202);
    // mean 0.25 rounds down, 0.75 rounds up
    send_pixel(24'h010003);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
  endtask

  // widest and tallest frames, written exactly and via saturation; each is
  // started, then shrunk to 3 x 2 under the position and continued there
  task automatic test_size_extremes();
    int unsigned widths  [4] = '{MaxWidth, 1500, MinDim, 0};
    int unsigned heights [4] = '{MinDim, 1, MaxHeight, 8191};
    int unsigned k;
    for (k = 0; k < 4; k++) begin
      set_frame(CfgDataW'(widths[k]), CfgDataW'(heights[k]));
      send_random_pixels(10, 10);
      set_frame(3, 2);
      send_random_pixels(6, 6);
    end
  endtask

  // whole frames of random small sizes, the first and some others paused
  // mid-frame until drained
  task automatic run_random_frames(input int unsigned target);
    int unsigned sent, w_data, h_data, npix;
    sent = 0;
    while (sent < target) begin
      w_data = ($urandom_range(4) == 0) ? $urandom_range(10, 20) : $urandom_range(9);
      h_data = $urandom_range(6);
      // bits above the 11-bit width register are dropped
      if ($urandom_range(5) == 0) w_data += 2048 * $urandom_range(1, 3);
      set_frame(CfgDataW'(w_data), CfgDataW'(h_data));
      npix = frame_pixels();
      send_random_pixels(npix, (sent == 0 || $urandom_range(3) == 0) ?
                               $urandom_range(npix - 1) : npix);
      sent += npix;
    end
  endtask

  initial begin
    int unsigned k;
    for (k = 0; k < MaxWidth; k++) begin
      older_line[k] = '0;
      prev_line[k]  = '0;
    end
    for (k = 0; k < 6; k++) window_cols[k] = '0;

    // light sender gaps, heavy receiver stalls
    src_idle_pct   = 7;
    sink_stall_pct = 46;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size_and_shrink();
    test_directed_pixels();
    run_random_frames(35);

    // heavy sender gaps, light receiver stalls
    src_idle_pct   = 46;
    sink_stall_pct = 7;
    run_random_frames(35);

    // full rate both ways
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_size_extremes();
    run_random_frames(35);

    drain_results();
    $display("%0d pixels in, %0d blurred words checked, %0d register writes",
             pixels_sent, words_checked, reg_writes);
    $display("small whole frames, clamped sizes, widest and tallest frames shrunk mid-frame");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== box_blur_3x3_rgb_unit.f =====
rtl/core/bb3_pkg.sv
rtl/core/bb3_line_store.sv
rtl/core/bb3_mean_unit.sv
rtl/core/box_blur_3x3_rgb_unit.sv
tb/tb_box_blur_3x3_rgb_unit.sv
